[rtl/gdd_pkg.sv]
// ----------------------------------------------------------------------------
// gdd_pkg
// Types, constants and calendar tables for the Gregorian date difference block.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int unsigned YEAR_MAX    = 9999;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned ORD_W       = 9;
  localparam int unsigned DIST_W      = 22;
  localparam int unsigned SERIAL_W    = 23;
  localparam int unsigned Q100_W      = 8;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned PROD_W      = YEAR_W + RECIP_W;

  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
  localparam logic [RECIP_W-1:0]  RECIP_100   = RECIP_W'(5243);
  localparam logic [6:0]          HUNDRED     = 7'd100;
  localparam logic [8:0]          DAYS_COMMON = 9'd365;
  localparam logic [MONTH_W-1:0]  MONTH_FEB   = MONTH_W'(2);
  localparam logic [MONTH_W-1:0]  MONTH_DEC   = MONTH_W'(12);
  localparam logic [YEAR_W-1:0]   YEAR_LIMIT  = YEAR_W'(YEAR_MAX);
  localparam logic [DIST_W-1:0]   DIST_MAX    = '1;

  localparam logic signed [1:0] ORDER_LATER   = 2'sd1;
  localparam logic signed [1:0] ORDER_EARLIER = -2'sd1;
  localparam logic signed [1:0] ORDER_EQUAL   = 2'sd0;

  typedef struct packed {
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
  } req_t;

  typedef struct packed {
    logic signed [1:0]  order;
    logic [DIST_W-1:0]  day_distance;
    logic [ORD_W-1:0]   first_day_of_year;
    logic [ORD_W-1:0]   second_day_of_year;
    logic               first_leap;
    logic               second_leap;
    logic               first_valid;
    logic               second_valid;
  } res_t;

  typedef struct packed {
    logic                leap;
    logic                valid;
    logic [ORD_W-1:0]    ordinal;
    logic [SERIAL_W-1:0] serial;
  } date_info_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [ORD_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [ORD_W-1:0] start;
    unique case (m)
      4'd1:    start = 9'd0;
      4'd2:    start = 9'd31;
      4'd3:    start = 9'd59;
      4'd4:    start = 9'd90;
      4'd5:    start = 9'd120;
      4'd6:    start = 9'd151;
      4'd7:    start = 9'd181;
      4'd8:    start = 9'd212;
      4'd9:    start = 9'd243;
      4'd10:   start = 9'd273;
      4'd11:   start = 9'd304;
      4'd12:   start = 9'd334;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

[rtl/gregorian_date_difference.sv]
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Validity, leap flag, ordinal day and order of two Gregorian dates and the
// absolute number of days between them.
// ----------------------------------------------------------------------------
// A new date pair is taken in every cycle in which start is high; busy is
// always low, so one pair per clock is sustained. Each pair gives exactly one
// result, shown on res for a single cycle with done high; between the edge that
// takes the pair and done lie the input register, three date pipeline stages
// and the result register.
// Results leave in the order the pairs came in and the receiver must take
// each one in the cycle it appears.
module gregorian_date_difference (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  gdd_pkg::req_t req,
  output logic          done,
  output gdd_pkg::res_t res
);

  gdd_pkg::req_t req_a;
  logic          vld_a;
  logic          vld_b;
  logic          vld_c;
  logic          vld_d;
  logic signed [1:0] order_a;
  logic signed [1:0] order_b;
  logic signed [1:0] order_c;
  logic signed [1:0] order_d;

  gdd_pkg::date_info_t first_info;
  gdd_pkg::date_info_t second_info;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
    end else begin
      vld_a <= start && !busy;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_d <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    req_a   <= req;
    order_b <= order_a;
    order_c <= order_b;
    order_d <= order_c;
  end

  // raw field order: year, then month, then day
  always_comb begin
    priority if (req_a.first_year != req_a.second_year) begin
      order_a = (req_a.first_year > req_a.second_year) ?
                gdd_pkg::ORDER_LATER : gdd_pkg::ORDER_EARLIER;
    end else if (req_a.first_month != req_a.second_month) begin
      order_a = (req_a.first_month > req_a.second_month) ?
                gdd_pkg::ORDER_LATER : gdd_pkg::ORDER_EARLIER;
    end else if (req_a.first_day != req_a.second_day) begin
      order_a = (req_a.first_day > req_a.second_day) ?
                gdd_pkg::ORDER_LATER : gdd_pkg::ORDER_EARLIER;
    end else begin
      order_a = gdd_pkg::ORDER_EQUAL;
    end
  end

  gdd_date_unit u_first (
    .clk   (clk),
    .day   (req_a.first_day),
    .month (req_a.first_month),
    .year  (req_a.first_year),
    .info  (first_info)
  );

  gdd_date_unit u_second (
    .clk   (clk),
    .day   (req_a.second_day),
    .month (req_a.second_month),
    .year  (req_a.second_year),
    .info  (second_info)
  );

  gdd_result u_result (
    .clk         (clk),
    .rst         (rst),
    .vld         (vld_d),
    .order       (order_d),
    .first_info  (first_info),
    .second_info (second_info),
    .done        (done),
    .res         (res)
  );

endmodule

[rtl/gdd_date_unit.sv]
// ----------------------------------------------------------------------------
// gdd_date_unit
// Three-stage pipeline for one date: leap flag, validity, ordinal day and
// day number counted from 1 January of year 1.
// ----------------------------------------------------------------------------
module gdd_date_unit (
  input  logic                         clk,
  input  logic [gdd_pkg::DAY_W-1:0]    day,
  input  logic [gdd_pkg::MONTH_W-1:0]  month,
  input  logic [gdd_pkg::YEAR_W-1:0]   year,
  output gdd_pkg::date_info_t          info
);

  // stage b: reciprocal divide and year scaling
  logic [gdd_pkg::DAY_W-1:0]    day_b;
  logic [gdd_pkg::MONTH_W-1:0]  month_b;
  logic [gdd_pkg::YEAR_W-1:0]   year_b;
  logic [gdd_pkg::YEAR_W-1:0]   prev_b;
  logic [gdd_pkg::Q100_W-1:0]   q100_b;
  logic [gdd_pkg::SERIAL_W-1:0] p365_b;

  logic [gdd_pkg::PROD_W-1:0]   recip_prod;
  logic [gdd_pkg::YEAR_W-1:0]   prev_year;

  assign recip_prod = gdd_pkg::PROD_W'(year) * gdd_pkg::PROD_W'(gdd_pkg::RECIP_100);
  assign prev_year  = year - gdd_pkg::YEAR_W'(1);

  always_ff @(posedge clk) begin
    day_b   <= day;
    month_b <= month;
    year_b  <= year;
    prev_b  <= prev_year;
    q100_b  <= gdd_pkg::Q100_W'(recip_prod >> gdd_pkg::RECIP_SHIFT);
    p365_b  <= gdd_pkg::SERIAL_W'(prev_year) * gdd_pkg::SERIAL_W'(gdd_pkg::DAYS_COMMON);
  end

  // stage c: leap, validity, ordinal
  logic [gdd_pkg::YEAR_W-1:0] rem100;
  logic                       leap;
  logic [gdd_pkg::DAY_W:0]    day_lim;
  logic                       valid;
  logic [gdd_pkg::ORD_W-1:0]  ordinal;

  assign rem100 = year_b - (gdd_pkg::YEAR_W'(q100_b) * gdd_pkg::YEAR_W'(gdd_pkg::HUNDRED));
  assign leap   = (year_b[1:0] == 2'b00) && ((rem100 != '0) || (q100_b[1:0] == 2'b00));

  always_comb begin
    day_lim = {1'b0, gdd_pkg::month_len(month_b)};
    if (month_b == gdd_pkg::MONTH_FEB && leap) begin
      day_lim = day_lim + (gdd_pkg::DAY_W+1)'(1);
    end
    valid = (day_b != '0) && (month_b != '0) && (month_b <= gdd_pkg::MONTH_DEC) &&
            (year_b != '0) && (year_b <= gdd_pkg::YEAR_LIMIT) &&
            ({1'b0, day_b} <= day_lim);
    ordinal = gdd_pkg::month_start(month_b) + gdd_pkg::ORD_W'(day_b) +
              gdd_pkg::ORD_W'(leap && (month_b > gdd_pkg::MONTH_FEB));
  end

  logic                         leap_c;
  logic                         valid_c;
  logic [gdd_pkg::ORD_W-1:0]    ord_c;
  logic [gdd_pkg::YEAR_W-1:0]   prev_c;
  logic [gdd_pkg::Q100_W-1:0]   pq100_c;
  logic [gdd_pkg::SERIAL_W-1:0] p365_c;

  always_ff @(posedge clk) begin
    leap_c  <= leap;
    valid_c <= valid;
    ord_c   <= ordinal;
    prev_c  <= prev_b;
    // (y - 1) / 100 drops by one when y is a multiple of 100
    pq100_c <= q100_b - gdd_pkg::Q100_W'(rem100 == '0);
    p365_c  <= p365_b;
  end

  // stage d: day number
  always_ff @(posedge clk) begin
    info.leap    <= leap_c;
    info.valid   <= valid_c;
    info.ordinal <= ord_c;
    info.serial  <= p365_c
                  + gdd_pkg::SERIAL_W'(prev_c >> 2)
                  - gdd_pkg::SERIAL_W'(pq100_c)
                  + gdd_pkg::SERIAL_W'(pq100_c >> 2)
                  + gdd_pkg::SERIAL_W'(ord_c);
  end

endmodule

[rtl/gdd_result.sv]
// ----------------------------------------------------------------------------
// gdd_result
// Result stage: absolute day difference, saturation, masking of invalid
// pairs and the result register with its strobe.
// ----------------------------------------------------------------------------
module gdd_result (
  input  logic                clk,
  input  logic                rst,
  input  logic                vld,
  input  logic signed [1:0]   order,
  input  gdd_pkg::date_info_t first_info,
  input  gdd_pkg::date_info_t second_info,
  output logic                done,
  output gdd_pkg::res_t       res
);

  logic                         both_valid;
  logic [gdd_pkg::SERIAL_W-1:0] diff;
  logic [gdd_pkg::DIST_W-1:0]   distance;

  assign both_valid = first_info.valid && second_info.valid;

  always_comb begin
    if (first_info.serial > second_info.serial) begin
      diff = first_info.serial - second_info.serial;
    end else begin
      diff = second_info.serial - first_info.serial;
    end
    if (diff > gdd_pkg::SERIAL_W'(gdd_pkg::DIST_MAX)) begin
      distance = gdd_pkg::DIST_MAX;
    end else begin
      distance = gdd_pkg::DIST_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld;
    end
  end

  always_ff @(posedge clk) begin
    res.order              <= order;
    res.day_distance       <= both_valid ? distance : '0;
    res.first_day_of_year  <= both_valid ? first_info.ordinal : '0;
    res.second_day_of_year <= both_valid ? second_info.ordinal : '0;
    res.first_leap         <= first_info.leap;
    res.second_leap        <= second_info.leap;
    res.first_valid        <= first_info.valid;
    res.second_valid       <= second_info.valid;
  end

endmodule
